>>> sv/srsw_pkg.sv
// types and constants shared by the selective-repeat sender window
`timescale 1ns / 1ps

package srsw_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SEGMENT = 1'b1;

  localparam int WSIZE_W = 6;
  localparam int SEQ_W   = 32;

  // event codes on the input channel
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // result codes on the output channel
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_LO,
    ST_EVAL_HI,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // request to the shared add and compare unit
  typedef struct packed {
    logic [SEQ_W:0] a;
    logic [SEQ_W:0] b;
    logic           cin;
    logic [SEQ_W:0] lim;
  } unit_req_t;

  // answer from the shared add and compare unit
  typedef struct packed {
    logic [SEQ_W:0] sum;
    logic           le;
    logic           zero;
  } unit_rsp_t;

endpackage

>>> sv/srsw_ifs.sv
// valid/ready channel interfaces for events in and results out
`timescale 1ns / 1ps

interface srsw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] ack_seq;
  logic [31:0] ack_bitmap;

  modport source (output valid, output mode, output ack_seq, output ack_bitmap,
                  input ready);
  modport sink (input valid, input mode, input ack_seq, input ack_bitmap,
                output ready);
endinterface

interface srsw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] segment_seq;
  logic        last_of_run;

  modport source (output valid, output result_kind, output segment_seq,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input segment_seq,
                input last_of_run, output ready);
endinterface

>>> sv/selective_repeat_sender_window.sv
// Selective-repeat sender window. Each event item (start, ack, timeout) is
// taken when the block is idle and answered with a run of result items,
// which may be empty: segment numbers to send, or one completion or abort
// report, the last one marked by last_of_run. A start or a timeout resend
// scans the window from the base, and an ack that slides the window scans
// positions beyond the old window; a scan looks at up to the effective
// window, at most MAX_WINDOW, positions; one shared 33-bit add and compare
// unit checks one window position per cycle while results are not stalled.
// Results pass through an output register, and a stalled result side holds
// the scan. The user must write the configuration registers only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int MAX_WINDOW = 32,
  parameter int MAX_TRIES  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  srsw_in_if.sink               in_ch,
  srsw_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WSIZE_W-1:0] win_size;
  logic [SEQ_W-1:0]   last_segment;
  unit_req_t          unit_req;
  unit_rsp_t          unit_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size     <= WSIZE_W'(4);
      last_segment <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  win_size     <= cfg_data[WSIZE_W-1:0];
        REG_LAST_SEGMENT: last_segment <= cfg_data[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and window state
  srsw_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_TRIES  (MAX_TRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_mode      (in_ch.mode),
    .in_ack       (in_ch.ack_seq),
    .in_bits      (in_ch.ack_bitmap),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.result_kind),
    .out_seq      (out_ch.segment_seq),
    .out_last     (out_ch.last_of_run),
    .win_size     (win_size),
    .last_segment (last_segment),
    .unit_req     (unit_req),
    .unit_rsp     (unit_rsp)
  );

  // shared add and compare unit
  srsw_alu u_alu (
    .req (unit_req),
    .rsp (unit_rsp)
  );

endmodule

>>> sv/srsw_alu.sv
// shared 33-bit add and compare unit used by the sequencer's evaluation and scan states
`timescale 1ns / 1ps

module srsw_alu
  import srsw_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [SEQ_W:0] sum;

  // one add with carry in, then a compare against the limit
  assign sum      = req.a + req.b + {{SEQ_W{1'b0}}, req.cin};
  assign rsp.sum  = sum;
  assign rsp.le   = (sum <= req.lim);
  assign rsp.zero = (sum == '0);

endmodule

>>> sv/srsw_ctrl.sv
// window state, event sequencer and result register
`timescale 1ns / 1ps

module srsw_ctrl
  import srsw_pkg::*;
#(
  parameter int MAX_WINDOW = 32,
  parameter int MAX_TRIES  = 5
) (
  input  logic               clk,
  input  logic               rst,
  // event side
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [SEQ_W-1:0]   in_ack,
  input  logic [SEQ_W-1:0]   in_bits,
  // result side
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [SEQ_W-1:0]   out_seq,
  output logic               out_last,
  // configuration
  input  logic [WSIZE_W-1:0] win_size,
  input  logic [SEQ_W-1:0]   last_segment,
  // shared unit
  output unit_req_t          unit_req,
  input  unit_rsp_t          unit_rsp
);

  localparam int OW = $clog2(2 * MAX_WINDOW + 1);
  localparam int RW = $clog2(MAX_TRIES + 1);

  state_t           state, state_next;
  logic [SEQ_W-1:0] base, base_next;
  logic [SEQ_W-1:0] acked, acked_next;
  logic [RW-1:0]    retry, retry_next;
  logic             running, running_next;
  logic [SEQ_W-1:0] ack_r, ack_r_next;
  logic [SEQ_W-1:0] bits_r, bits_r_next;
  logic [SEQ_W-1:0] diff, diff_next;
  logic [OW-1:0]    offset, offset_next;
  logic [OW-1:0]    stop, stop_next;
  logic             slide, slide_next;
  logic             pend_valid, pend_valid_next;
  logic [1:0]       pend_kind, pend_kind_next;
  logic [SEQ_W-1:0] pend_seq, pend_seq_next;
  logic             out_valid_next;
  logic [1:0]       out_kind_next;
  logic [SEQ_W-1:0] out_seq_next;
  logic             out_last_next;

  logic [OW-1:0]    w_eff;
  logic [OW-1:0]    steps;
  logic             out_free;
  logic             scan_end;
  logic             skip;
  logic [4:0]       bit_idx;

  // clamp the window to 1 .. MAX_WINDOW
  always_comb begin
    if (win_size == '0) begin
      w_eff = OW'(1);
    end else if (win_size > WSIZE_W'(MAX_WINDOW)) begin
      w_eff = OW'(MAX_WINDOW);
    end else begin
      w_eff = OW'(win_size);
    end
  end

  // slide count clamped to the window
  assign steps = (diff > SEQ_W'(w_eff)) ? w_eff : OW'(diff);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // scan step decisions, from the unit answer for base + offset
  assign bit_idx  = 5'(offset - OW'(1));
  assign scan_end = (offset == stop) || !unit_rsp.le;
  assign skip     = !slide && (offset != '0) && acked[bit_idx];

  // operand selection for the shared unit
  always_comb begin
    unit_req.a   = {1'b0, base};
    unit_req.b   = (SEQ_W + 1)'(offset);
    unit_req.cin = 1'b0;
    unit_req.lim = {1'b0, last_segment};
    case (state)
      ST_EVAL_LO: begin
        // ack - base, sign bit set when the ack lies behind the base
        unit_req.a   = {1'b0, ack_r};
        unit_req.b   = ~{1'b0, base};
        unit_req.cin = 1'b1;
      end
      ST_EVAL_HI: begin
        // ack - last - 1, zero when the ack is one past the last segment
        unit_req.a   = {1'b0, ack_r};
        unit_req.b   = ~{1'b0, last_segment};
        unit_req.cin = 1'b0;
      end
      default: ;
    endcase
  end

  // sequencer: next state and register updates
  always_comb begin
    state_next      = state;
    base_next       = base;
    acked_next      = acked;
    retry_next      = retry;
    running_next    = running;
    ack_r_next      = ack_r;
    bits_r_next     = bits_r;
    diff_next       = diff;
    offset_next     = offset;
    stop_next       = stop;
    slide_next      = slide;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_seq_next   = pend_seq;
    out_valid_next  = out_valid;
    out_kind_next   = out_kind;
    out_seq_next    = out_seq;
    out_last_next   = out_last;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ack_r_next  = in_ack;
          bits_r_next = in_bits;
          case (in_mode)
            MODE_START: begin
              running_next = 1'b1;
              base_next    = '0;
              acked_next   = '0;
              retry_next   = '0;
              offset_next  = '0;
              stop_next    = w_eff;
              slide_next   = 1'b0;
              state_next   = ST_SCAN;
            end
            MODE_ACK: begin
              if (running) begin
                retry_next = '0;
                state_next = ST_EVAL_LO;
              end
            end
            MODE_TIMEOUT: begin
              if (running) begin
                if (retry >= RW'(MAX_TRIES - 1)) begin
                  running_next    = 1'b0;
                  retry_next      = '0;
                  pend_valid_next = 1'b1;
                  pend_kind_next  = KIND_ABORT;
                  pend_seq_next   = '0;
                  state_next      = ST_FLUSH;
                end else begin
                  retry_next  = retry + RW'(1);
                  offset_next = '0;
                  stop_next   = w_eff;
                  slide_next  = 1'b0;
                  state_next  = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_EVAL_LO: begin
        if (unit_rsp.sum[SEQ_W]) begin
          // ack behind the base is dropped
          state_next = ST_IDLE;
        end else begin
          acked_next = bits_r;
          diff_next  = unit_rsp.sum[SEQ_W-1:0];
          state_next = unit_rsp.zero ? ST_IDLE : ST_EVAL_HI;
        end
      end

      ST_EVAL_HI: begin
        if (unit_rsp.zero) begin
          running_next    = 1'b0;
          pend_valid_next = 1'b1;
          pend_kind_next  = KIND_DONE;
          pend_seq_next   = '0;
          state_next      = ST_FLUSH;
        end else begin
          offset_next = w_eff;
          stop_next   = w_eff + steps;
          slide_next  = 1'b1;
          state_next  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (scan_end) begin
          if (slide) begin
            base_next = ack_r;
          end
          state_next = ST_FLUSH;
        end else if (skip) begin
          offset_next = offset + OW'(1);
        end else if (!pend_valid || out_free) begin
          // hand the held segment on, hold the new one
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind;
            out_seq_next   = pend_seq;
            out_last_next  = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_kind_next  = KIND_SEND;
          pend_seq_next   = unit_rsp.sum[SEQ_W-1:0];
          offset_next     = offset + OW'(1);
        end
      end

      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = pend_kind;
          out_seq_next    = pend_seq;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base       <= '0;
      acked      <= '0;
      retry      <= '0;
      running    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      base       <= base_next;
      acked      <= acked_next;
      retry      <= retry_next;
      running    <= running_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ack_r     <= ack_r_next;
    bits_r    <= bits_r_next;
    diff      <= diff_next;
    offset    <= offset_next;
    stop      <= stop_next;
    slide     <= slide_next;
    pend_kind <= pend_kind_next;
    pend_seq  <= pend_seq_next;
    out_kind  <= out_kind_next;
    out_seq   <= out_seq_next;
    out_last  <= out_last_next;
  end

endmodule

>>> sv/srsw_checker.sv
// port-level checks for the selective-repeat sender window, with its bind
`timescale 1ns / 1ps

module srsw_checker
  import srsw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_seq,
  input logic        out_last
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_seq)
      && $stable(out_last))
    else $error("result changed while stalled");

  // completion and abort reports stand alone with no segment number
  a_report_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ABORT)
      |-> out_last && (out_seq == '0))
    else $error("malformed completion or abort report");

  // only the three result codes appear
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_SEND || out_kind == KIND_DONE
      || out_kind == KIND_ABORT))
    else $error("illegal result code");

  // a start item always occupies the block for at least the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_START) |=> !in_ready)
    else $error("ready after start item");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_seq   (out_ch.segment_seq),
  .out_last  (out_ch.last_of_run)
);
